FILE: src/tlzw_pkg.sv
// shared constants and types for the tiff lzw decoder
package tlzw_pkg;

   localparam int CODE_CLEAR = 256;
   localparam int CODE_END   = 257;
   localparam int FIRST_FREE = 258;
   localparam int MIN_WIDTH  = 9;

   localparam int PEND_W      = 13;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 4;

   typedef enum logic [2:0] {
      ST_NONE,
      ST_DECODED,
      ST_CLEAR,
      ST_END,
      ST_BAD,
      ST_BUSY,
      ST_IGNORED,
      ST_PULL
   } status_type;

endpackage

FILE: src/tiff_lzw_decoder.sv
// TIFF LZW decoder: 9 to MAX_CODE_BITS bit codes, prefix/suffix table, byte stack
// Each request transfer either supplies one compressed byte (tuser 0) or pulls one decoded
// byte (tuser 1), and produces exactly one response transfer. A pull reads the stack top, a
// byte that completes no code (or is refused or ignored) goes straight to the response, a
// clear, end or bad code or the first code after a clear is handled in the code state, and
// any other code is walked (for the code not yet in the table, from the previous code after
// pushing its first byte): the string is stacked by walking the prefix chain through the code
// table, one registered read per byte. Bytes
// are refused with status busy while decoded output is still pending, so the stack must
// be drained by pulls before more compressed data is sent. The table and stack memories
// need no clearing after reset; the block is ready in the cycle after reset is released.
// The next request is taken while a response still waits in the output register.
module tiff_lzw_decoder
   import tlzw_pkg::*;
#(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // data_byte
   input  logic [0:0]             req_tuser,   // mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // out_byte, pending_bytes, zero pad
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // status, byte_valid
   output logic                   rsp_tlast    // last_of_string
);

   localparam int CODE_W   = MAX_CODE_BITS;
   localparam int CNT_W    = MAX_CODE_BITS + 1;
   localparam int ACC_W    = MAX_CODE_BITS + 7;
   localparam int HELD_W   = $clog2(MAX_CODE_BITS + 8);
   localparam int WID_W    = $clog2(MAX_CODE_BITS + 1);
   localparam int TBL_SIZE = 1 << MAX_CODE_BITS;
   localparam int ENTRY_W  = CODE_W + 8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CODE,
      S_WALK,
      S_STEP,
      S_PULL,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [HELD_W-1:0]   held_ff, held_in;
   logic [WID_W-1:0]    width_ff, width_in;
   logic [CNT_W-1:0]    nfc_ff, nfc_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CODE_W-1:0]   prev_ff, prev_in;
   logic [7:0]          pfc_ff, pfc_in;
   logic                fac_ff, fac_in;
   logic                ended_ff, ended_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [CODE_W-1:0]   walk_ff, walk_in;
   status_type          res_status_ff, res_status_in;
   logic [7:0]          res_byte_ff, res_byte_in;
   logic                res_valid_ff, res_valid_in;
   logic                res_last_ff, res_last_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_bvalid_ff, rsp_bvalid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [PEND_W-1:0]   rsp_pend_ff, rsp_pend_in;

   logic [ENTRY_W-1:0]  tbl_mem [TBL_SIZE];
   logic [ENTRY_W-1:0]  tbl_q;
   logic                tbl_we;
   logic [ENTRY_W-1:0]  tbl_wdata;
   logic [7:0]          stk_mem [TBL_SIZE];
   logic [7:0]          stk_q;
   logic                stk_we;
   logic [7:0]          stk_wdata;

   logic [ACC_W-1:0]    acc_cat;
   logic [HELD_W-1:0]   held_add;
   logic [HELD_W-1:0]   width_ext;
   logic [HELD_W-1:0]   sh;
   logic [CODE_W-1:0]   code_mask;
   logic [CODE_W-1:0]   code_cat;
   logic [ACC_W-1:0]    acc_keep;
   logic [CNT_W-1:0]    cnt_dec;
   logic [CNT_W-1:0]    nfc_inc;
   logic [CNT_W-1:0]    width_lim;
   logic                out_free;
   logic                load_rsp;
   logic [7:0]          ld_byte;
   logic                push_en;
   logic [7:0]          push_byte;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - PEND_W - 8){1'b0}}, rsp_pend_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_bvalid_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   // bit gathering, msb first
   assign acc_cat   = {acc_ff[ACC_W-9:0], req_tdata};
   assign held_add  = held_ff + HELD_W'(8);
   assign width_ext = HELD_W'(width_ff);
   assign sh        = held_add - width_ext;
   assign code_mask = ~({CODE_W{1'b1}} << width_ff);
   assign code_cat  = CODE_W'(acc_cat >> sh) & code_mask;
   assign acc_keep  = acc_cat & ~({ACC_W{1'b1}} << sh);

   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign nfc_inc   = nfc_ff + CNT_W'(1);
   assign width_lim = (CNT_W'(1) << width_ff) - CNT_W'(1);
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign tbl_wdata = {prev_ff, walk_ff[7:0]};

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      held_in       = held_ff;
      width_in      = width_ff;
      nfc_in        = nfc_ff;
      cnt_in        = cnt_ff;
      prev_in       = prev_ff;
      pfc_in        = pfc_ff;
      fac_in        = fac_ff;
      ended_in      = ended_ff;
      code_in       = code_ff;
      walk_in       = walk_ff;
      res_status_in = res_status_ff;
      res_byte_in   = res_byte_ff;
      res_valid_in  = res_valid_ff;
      res_last_in   = res_last_ff;
      tbl_we        = 1'b0;
      push_en       = 1'b0;
      push_byte     = 8'd0;
      load_rsp      = 1'b0;
      ld_byte       = res_byte_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               res_byte_in  = 8'd0;
               res_valid_in = 1'b0;
               res_last_in  = 1'b0;
               state_in     = S_RESP;
               if (req_tuser[0]) begin
                  res_status_in = ST_PULL;
                  if (cnt_ff != '0) begin
                     cnt_in       = cnt_dec;
                     res_valid_in = 1'b1;
                     res_last_in  = (cnt_dec == '0);
                     state_in     = S_PULL;
                  end
               end else if (ended_ff) begin
                  res_status_in = ST_IGNORED;
               end else if (cnt_ff != '0) begin
                  res_status_in = ST_BUSY;
               end else begin
                  res_status_in = ST_NONE;
                  acc_in        = acc_cat;
                  held_in       = held_add;
                  if (held_add >= width_ext) begin
                     code_in  = code_cat;
                     acc_in   = acc_keep;
                     held_in  = sh;
                     state_in = S_CODE;
                  end
               end
            end
         end
         S_CODE: begin
            state_in = S_RESP;
            if (code_ff == CODE_W'(CODE_END)) begin
               ended_in      = 1'b1;
               acc_in        = '0;
               held_in       = '0;
               res_status_in = ST_END;
            end else if (code_ff == CODE_W'(CODE_CLEAR)) begin
               nfc_in        = CNT_W'(FIRST_FREE);
               width_in      = WID_W'(MIN_WIDTH);
               fac_in        = 1'b1;
               res_status_in = ST_CLEAR;
            end else if (fac_ff) begin
               if (code_ff >= CODE_W'(CODE_CLEAR)) begin
                  res_status_in = ST_BAD;
               end else begin
                  push_en       = 1'b1;
                  push_byte     = code_ff[7:0];
                  prev_in       = code_ff;
                  pfc_in        = code_ff[7:0];
                  fac_in        = 1'b0;
                  res_status_in = ST_DECODED;
               end
            end else if ({1'b0, code_ff} < nfc_ff) begin
               walk_in  = code_ff;
               state_in = S_WALK;
            end else if ({1'b0, code_ff} == nfc_ff) begin
               // code not yet in the table: string of previous code plus its first byte
               push_en   = 1'b1;
               push_byte = pfc_ff;
               walk_in   = prev_ff;
               state_in  = S_WALK;
            end else begin
               res_status_in = ST_BAD;
            end
         end
         S_WALK: begin
            if (walk_ff >= CODE_W'(FIRST_FREE)) begin
               state_in = S_STEP;
            end else begin
               push_en   = 1'b1;
               push_byte = walk_ff[7:0];
               if (!nfc_ff[CNT_W-1]) begin
                  tbl_we = 1'b1;
                  nfc_in = nfc_inc;
                  if (width_ff < WID_W'(MAX_CODE_BITS) && nfc_inc == width_lim) begin
                     width_in = width_ff + WID_W'(1);
                  end
               end
               prev_in       = code_ff;
               pfc_in        = walk_ff[7:0];
               res_status_in = ST_DECODED;
               state_in      = S_RESP;
            end
         end
         S_STEP: begin
            push_en   = 1'b1;
            push_byte = tbl_q[7:0];
            walk_in   = tbl_q[ENTRY_W-1:8];
            state_in  = S_WALK;
         end
         S_PULL: begin
            ld_byte     = stk_q;
            res_byte_in = stk_q;
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      stk_we    = push_en && !cnt_ff[CNT_W-1];
      stk_wdata = push_byte;
      if (stk_we) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_pend_in   = rsp_pend_ff;
      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_byte_in   = ld_byte;
         rsp_bvalid_in = res_valid_ff;
         rsp_last_in   = res_last_ff;
         rsp_pend_in   = PEND_W'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[nfc_ff[CODE_W-1:0]] <= tbl_wdata;
      end
      tbl_q <= tbl_mem[walk_ff];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[cnt_ff[CODE_W-1:0]] <= stk_wdata;
      end
      stk_q <= stk_mem[cnt_dec[CODE_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         acc_ff        <= '0;
         held_ff       <= '0;
         width_ff      <= WID_W'(MIN_WIDTH);
         nfc_ff        <= CNT_W'(FIRST_FREE);
         cnt_ff        <= '0;
         prev_ff       <= '0;
         pfc_ff        <= '0;
         fac_ff        <= 1'b1;
         ended_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         held_ff       <= held_in;
         width_ff      <= width_in;
         nfc_ff        <= nfc_in;
         cnt_ff        <= cnt_in;
         prev_ff       <= prev_in;
         pfc_ff        <= pfc_in;
         fac_ff        <= fac_in;
         ended_ff      <= ended_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      code_ff       <= code_in;
      walk_ff       <= walk_in;
      res_status_ff <= res_status_in;
      res_byte_ff   <= res_byte_in;
      res_valid_ff  <= res_valid_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_pend_ff   <= rsp_pend_in;
   end

endmodule

FILE: src/tlzw_checker.sv
// port-level checks for the tiff lzw decoder, bound to the top level
module tlzw_props
   import tlzw_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [7:0]             req_tdata,
   input logic [0:0]             req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser,
   input logic                   rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_byte_only_on_pull: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == ST_PULL)
      else $error("valid byte outside a pull");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[3] && rsp_tdata[20:8] == '0)
      else $error("last byte with output still pending");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[3] |-> rsp_tdata[7:0] == 8'd0 && !rsp_tlast)
      else $error("byte data without a valid byte");

endmodule

bind tiff_lzw_decoder tlzw_props u_tlzw_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
